// ===== hdl/hds_pkg.sv =====
// Shared types and constants of the heat diffusion stencil sweep.
package hds_pkg;

	localparam int SIZE_BITS      = 10;
	localparam int GAIN_BITS      = 16;
	localparam int GAIN_SHIFT     = 18;  // Q0.16 gain plus the divide by four
	localparam int APB_DATA_BITS  = 32;
	localparam int APB_ADDR_BITS  = 3;

	localparam logic [SIZE_BITS-1:0] SIZE_RESET = 10'd1022;
	localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd58982;  // 0.9 in Q0.16

	// Register index, taken from paddr[2]
	localparam logic REG_INTERIOR_SIZE  = 1'b0;
	localparam logic REG_DIFFUSION_GAIN = 1'b1;

	typedef struct packed {
		logic take;  // accepted cell completes an interior result
		logic last;  // that result is the final interior cell of the grid
	} hds_ctl_t;

endpackage

// ===== hdl/hds_line_mem.sv =====
// Line store: simple dual-port RAM, one write and one registered read per cycle.
module hds_line_mem #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/hds_stencil_calc.sv =====
// Stencil arithmetic pipeline: Laplacian, gain multiply, floor shift, saturation.
module hds_stencil_calc
	import hds_pkg::*;
#(
	parameter int CELL_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  hds_ctl_t                    ctl,
	input  logic signed [CELL_BITS-1:0] north,
	input  logic signed [CELL_BITS-1:0] south,
	input  logic signed [CELL_BITS-1:0] east,
	input  logic signed [CELL_BITS-1:0] west,
	input  logic signed [CELL_BITS-1:0] centre,
	input  logic        [GAIN_BITS-1:0] gain,
	output logic                        adv,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [CELL_BITS-1:0] new_value,
	output logic                        grid_done
);

	localparam int LW = CELL_BITS + 3;
	localparam int PW = LW + GAIN_BITS + 1;
	localparam logic signed [PW-1:0] CELL_MAX = (PW'(1) <<< (CELL_BITS - 1)) - PW'(1);
	localparam logic signed [PW-1:0] CELL_MIN = -CELL_MAX - PW'(1);

	logic                        valid_s1, last_s1, valid_s2, last_s2;
	logic signed [LW-1:0]        lap, lap_s1;
	logic signed [CELL_BITS-1:0] centre_s1, centre_s2;
	logic signed [GAIN_BITS:0]   gain_s;
	logic signed [PW-1:0]        prod_s2, delta, total, sat;
	logic                        out_valid_q, grid_done_q;
	logic signed [CELL_BITS-1:0] new_value_q;

	assign adv = !out_valid_q || out_ready;

	assign lap = LW'(north) + LW'(south) + LW'(east) + LW'(west) - (LW'(centre) <<< 2);
	assign gain_s = $signed({1'b0, gain});

	// Floor shift, then add the centre and clamp to the cell range
	assign delta = prod_s2 >>> GAIN_SHIFT;
	assign total = delta + PW'(centre_s2);

	always_comb begin
		if (total > CELL_MAX) begin
			sat = CELL_MAX;
		end else if (total < CELL_MIN) begin
			sat = CELL_MIN;
		end else begin
			sat = total;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			last_s1     <= 1'b0;
			valid_s2    <= 1'b0;
			last_s2     <= 1'b0;
			out_valid_q <= 1'b0;
			grid_done_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= ctl.take;
			last_s1     <= ctl.last;
			valid_s2    <= valid_s1;
			last_s2     <= last_s1;
			out_valid_q <= valid_s2;
			grid_done_q <= last_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lap_s1      <= lap;
			centre_s1   <= centre;
			prod_s2     <= PW'(lap_s1) * PW'(gain_s);
			centre_s2   <= centre_s1;
			new_value_q <= sat[CELL_BITS-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign new_value = new_value_q;
	assign grid_done = grid_done_q;

endmodule

// ===== hdl/heat_diffusion_stencil_sweep.sv =====
// Top level of the five-point heat diffusion stencil sweep.
//
// Usage: stream a padded square grid (interior plus a one-cell ghost border)
// into cell_value in row-major order, one item per in_valid/in_ready handshake.
// For every interior cell one item leaves on new_value with out_valid/out_ready:
// centre + alpha*(N+S+E+W-4*centre)/4, floored and saturated to the cell range.
// grid_done marks the final interior cell; after the last padded cell the next input starts a new grid.
//
// Both line stores share one RAM word per column {row r-2, row r-1}. Each
// accepted cell writes its column and prefetches column c+2, so the east
// neighbor is already in the RAM read register when the cell arrives.
// Throughput: one cell per cycle while the receiver is not stalling. The result for
// an interior cell passes the s1, s2 and output registers after the cell south of it is accepted.
// The arithmetic is three stages: Laplacian, gain multiply, shift/add/clamp.
//
// When the receiver stalls with a result waiting, the whole pipeline holds and
// in_ready drops until that result is taken.
// Reset clears the positions and sets the registers to their defaults; the
// RAM is not cleared, since the first two padded rows fill it before any
// result needs it. Writing interior_size restarts the grid at row 0, col 0.
module heat_diffusion_stencil_sweep
	import hds_pkg::*;
#(
	parameter int MAX_ROW   = 1024,
	parameter int CELL_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// input cells
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [CELL_BITS-1:0] cell_value,
	// results
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [CELL_BITS-1:0] new_value,
	output logic                        grid_done,
	// configuration
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [APB_ADDR_BITS-1:0]    paddr,
	input  logic [APB_DATA_BITS-1:0]    pwdata,
	output logic [APB_DATA_BITS-1:0]    prdata,
	output logic                        pready
);

	localparam int AW = $clog2(MAX_ROW);
	localparam int PW = ((AW + 1 > SIZE_BITS) ? AW + 1 : SIZE_BITS) + 1;
	localparam int WW = 2 * CELL_BITS;
	localparam logic [PW-1:0] SIZE_MAX = PW'(MAX_ROW - 2);

	logic                 cfg_wr, accept, adv;
	logic [SIZE_BITS-1:0] size_q;
	logic [GAIN_BITS-1:0] gain_q;
	logic [AW-1:0]        row_q, col_q;
	logic [PW-1:0]        eff_size, pad_len, row_w, col_w, nx_sum, nx_col;
	logic [WW-1:0]        cur_q, rd_word;
	logic signed [CELL_BITS-1:0] west_q, north, centre, east;
	hds_ctl_t             ctl;

	// Configuration port: zero wait states, register picked by paddr[2]
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
			gain_q <= GAIN_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_INTERIOR_SIZE:  size_q <= pwdata[SIZE_BITS-1:0];
				REG_DIFFUSION_GAIN: gain_q <= pwdata[GAIN_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_INTERIOR_SIZE:  prdata = APB_DATA_BITS'(size_q);
			REG_DIFFUSION_GAIN: prdata = APB_DATA_BITS'(gain_q);
			default:            prdata = '0;
		endcase
	end

	// Clamp the interior size to 1 .. MAX_ROW-2 and add the ghost border
	always_comb begin
		if (size_q == '0) begin
			eff_size = PW'(1);
		end else if (PW'(size_q) > SIZE_MAX) begin
			eff_size = SIZE_MAX;
		end else begin
			eff_size = PW'(size_q);
		end
	end
	assign pad_len = eff_size + PW'(2);

	assign row_w = PW'(row_q);
	assign col_w = PW'(col_q);

	// Prefetch column c+2, wrapped into the padded row
	assign nx_sum = col_w + PW'(2);
	assign nx_col = (nx_sum >= pad_len) ? nx_sum - pad_len : nx_sum;

	assign in_ready = adv;
	assign accept   = in_valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (cfg_wr && paddr[2] == REG_INTERIOR_SIZE) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (col_w == pad_len - PW'(1)) begin
				col_q <= '0;
				row_q <= (row_w == pad_len - PW'(1)) ? '0 : row_q + AW'(1);
			end else begin
				col_q <= col_q + AW'(1);
			end
		end
	end

	// Window: current column word, east from the prefetch, west from last centre
	assign north  = cur_q[WW-1:CELL_BITS];
	assign centre = cur_q[CELL_BITS-1:0];
	assign east   = rd_word[CELL_BITS-1:0];

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q  <= rd_word;
			west_q <= centre;
		end
	end

	assign ctl.take = accept && (row_w >= PW'(2)) && (col_w >= PW'(1))
		&& (col_w <= pad_len - PW'(2));
	assign ctl.last = (row_w == pad_len - PW'(1)) && (col_w == pad_len - PW'(2));

	hds_line_mem #(
		.DEPTH (MAX_ROW),
		.WIDTH (WW)
	) u_line_mem (
		.clk   (clk),
		.we    (accept),
		.waddr (col_q),
		.wdata ({centre, cell_value}),
		.re    (accept),
		.raddr (nx_col[AW-1:0]),
		.rdata (rd_word)
	);

	hds_stencil_calc #(
		.CELL_BITS (CELL_BITS)
	) u_calc (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.north     (north),
		.south     (cell_value),
		.east      (east),
		.west      (west_q),
		.centre    (centre),
		.gain      (gain_q),
		.adv       (adv),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.new_value (new_value),
		.grid_done (grid_done)
	);

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the heat diffusion stencil sweep.
`timescale 1ns / 100ps

module tb;
	import hds_pkg::*;

	localparam int MAX_ROW     = 1024;
	localparam int CELL_BITS   = 16;
	localparam int STALL_LIMIT = 4000;   // cycles with no item moving on either side
	localparam int DRAIN_WAIT  = 16;     // margin for results still in the pipeline registers
	localparam int RX_HOLD     = 300;    // long receiver hold-off, long enough to back up intake
	localparam int RANDOM_ITEMS = 650;
	localparam int PRESSURE_SIZE = 20;
	localparam longint CELL_MAX = (64'sd1 <<< (CELL_BITS - 1)) - 1;
	localparam longint CELL_MIN = -CELL_MAX - 1;

	typedef struct {
		logic [CELL_BITS-1:0] value;
		logic                 done;
	} cell_update_t;

	// One directed stimulus row: the cell to send, an optional gain write
	// ahead of it, and a hand-computed result where the row completes a cell.
	typedef struct packed {
		logic [CELL_BITS-1:0] stim;
		logic                 set_gain;
		logic [GAIN_BITS-1:0] gain;
		logic                 typed;
		logic [CELL_BITS-1:0] value;
	} seed_row_t;

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_ready;
	logic signed [CELL_BITS-1:0] cell_value;
	logic                        out_valid;
	logic                        out_ready;
	logic signed [CELL_BITS-1:0] new_value;
	logic                        grid_done;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [APB_ADDR_BITS-1:0]    paddr;
	logic [APB_DATA_BITS-1:0]    pwdata;
	logic [APB_DATA_BITS-1:0]    prdata;
	logic                        pready;

	// Predictor state: the two previous padded rows, the west cell kept
	// after its line entry moves up, the next input position and the registers.
	logic signed [CELL_BITS-1:0] upper_row [MAX_ROW];
	logic signed [CELL_BITS-1:0] middle_row [MAX_ROW];
	logic signed [CELL_BITS-1:0] west_cell;
	int unsigned                 row_pos;
	int unsigned                 col_pos;
	logic [SIZE_BITS-1:0]        size_reg;
	logic [GAIN_BITS-1:0]        gain_reg;

	cell_update_t expected_updates [$];
	int           mismatch_count = 0;
	int           quiet_cycles = 0;
	int           random_count = 0;
	bit           tx_calm = 1'b0;    // sender offers back to back
	bit           rx_calm = 1'b0;    // receiver never stalls
	bit           hold_request = 1'b0;

	// Three 3x3 padded grids (interior of one cell). The only result of each
	// grid is its centre cell, completed by the cell at the middle of the bottom row.
	seed_row_t directed_rows [27] = '{
		// full gain, cold centre under hot neighbors: lands one below the top
		'{16'h5555, 1'b0, 16'h0000, 1'b0, 16'h0000},
		'{16'h7FFF, 1'b0, 16'h0000, 1'b0, 16'h0000},
		'{16'hAAAA, 1'b0, 16'h0000, 1'b0, 16'h0000},
		'{16'h7FFF, 1'b0, 16'h0000, 1'b0, 16'h0000},
		'{16'h8000, 1'b0, 16'h0000, 1'b0, 16'h0000},
		'{16'h7FFF, 1'b0, 16'h0000, 1'b0, 16'h0000},
		'{16'h5555, 1'b0, 16'h0000, 1'b0, 16'h0000},
		'{16'h7FFF, 1'b0, 16'h0000, 1'b1, 16'h7FFE},
		'{16'hAAAA, 1'b0, 16'h0000, 1'b0, 16'h0000},
		// full gain, hot centre under cold neighbors: floor reaches the bottom
		'{16'h2AAA, 1'b0, 16'h0000, 1'b0, 16'h0000},
		'{16'h8000, 1'b0, 16'h0000, 1'b0, 16'h0000},
		'{16'hD555, 1'b0, 16'h0000, 1'b0, 16'h0000},
		'{16'h8000, 1'b0, 16'h0000, 1'b0, 16'h0000},
		'{16'h7FFF, 1'b0, 16'h0000, 1'b0, 16'h0000},
		'{16'h8000, 1'b0, 16'h0000, 1'b0, 16'h0000},
		'{16'h0001, 1'b0, 16'h0000, 1'b0, 16'h0000},
		'{16'h8000, 1'b0, 16'h0000, 1'b1, 16'h8000},
		'{16'hFFFE, 1'b0, 16'h0000, 1'b0, 16'h0000},
		// zero gain: the centre passes through untouched
		'{16'h0F0F, 1'b1, 16'h0000, 1'b0, 16'h0000},
		'{16'h4321, 1'b0, 16'h0000, 1'b0, 16'h0000},
		'{16'hF0F0, 1'b0, 16'h0000, 1'b0, 16'h0000},
		'{16'h8000, 1'b0, 16'h0000, 1'b0, 16'h0000},
		'{16'h1234, 1'b0, 16'h0000, 1'b0, 16'h0000},
		'{16'h7FFF, 1'b0, 16'h0000, 1'b0, 16'h0000},
		'{16'h00FF, 1'b0, 16'h0000, 1'b0, 16'h0000},
		'{16'hFFFF, 1'b0, 16'h0000, 1'b1, 16'h1234},
		'{16'hFF00, 1'b0, 16'h0000, 1'b0, 16'h0000}
	};

	heat_diffusion_stencil_sweep #(
		.MAX_ROW  (MAX_ROW),
		.CELL_BITS(CELL_BITS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cell_value(cell_value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.new_value (new_value),
		.grid_done (grid_done),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Padded row length; out-of-range sizes clamp to the nearest legal one.
	function automatic int unsigned padded_len();
		int unsigned n;
		n = 32'(size_reg);
		if (n < 1) n = 1;
		if (n > MAX_ROW - 2) n = MAX_ROW - 2;
		return n + 2;
	endfunction

	// Advance the stencil by one accepted cell; queue the updated interior
	// cell if this cell is the south neighbor of one. Return 1 on a result.
	function automatic bit diffuse_cell(input logic signed [CELL_BITS-1:0] south);
		int unsigned  pad;
		longint       north, centre, east, west, lap, updated;
		cell_update_t upd;
		bit           made;
		pad = padded_len();
		made = 1'b0;
		if (row_pos >= pad || col_pos >= pad) begin
			row_pos = 0;
			col_pos = 0;
		end
		if (row_pos >= 2 && col_pos >= 1 && col_pos <= pad - 2) begin
			north   = upper_row[col_pos];
			centre  = middle_row[col_pos];
			east    = middle_row[col_pos + 1];
			west    = west_cell;
			lap     = north + longint'(south) + east + west - 4 * centre;
			// arithmetic shift on a signed product floors toward minus infinity
			updated = centre + ((lap * longint'(gain_reg)) >>> GAIN_SHIFT);
			if (updated > CELL_MAX) updated = CELL_MAX;
			if (updated < CELL_MIN) updated = CELL_MIN;
			upd.value = updated[CELL_BITS-1:0];
			upd.done  = (row_pos == pad - 1 && col_pos == pad - 2);
			expected_updates.push_back(upd);
			made = 1'b1;
		end
		west_cell           = middle_row[col_pos];
		upper_row[col_pos]  = middle_row[col_pos];
		middle_row[col_pos] = south;
		col_pos++;
		if (col_pos >= pad) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= pad) row_pos = 0;
		end
		return made;
	endfunction

	// Mostly full-range noise, with the extremes and values near zero mixed in.
	function automatic logic [CELL_BITS-1:0] random_cell();
		case ($urandom_range(0, 7))
			0: begin
				return 16'h7FFF;
			end
			1: begin
				return 16'h8000;
			end
			2: begin
				return 16'($urandom_range(0, 63) - 32);
			end
			default: begin
				return 16'($urandom);
			end
		endcase
	endfunction

	// Offer one cell, hold it until accepted, then predict and draw the gap.
	// Where typed is set, the hand-computed value replaces the prediction.
	task automatic send_cell(input logic [CELL_BITS-1:0] stim, input bit typed,
		input logic [CELL_BITS-1:0] typed_value);
		int           gap;
		cell_update_t fixed;
		in_valid   <= 1'b1;
		cell_value <= stim;
		do @(posedge clk); while (!in_ready);
		if (diffuse_cell(stim) && typed) begin
			fixed.value = typed_value;
			fixed.done  = 1'b1;
			expected_updates[expected_updates.size() - 1] = fixed;
		end
		gap = tx_calm ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid, wait for every outstanding result, then let the tail of
	// border cells drain out of the pipeline.
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_updates.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(input logic index, input logic [APB_DATA_BITS-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {index, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		// mirror the write in the predictor; a size write restarts the grid
		if (index == REG_INTERIOR_SIZE) begin
			size_reg = value[SIZE_BITS-1:0];
			row_pos  = 0;
			col_pos  = 0;
		end else begin
			gain_reg = value[GAIN_BITS-1:0];
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_reg(input logic index, input logic [APB_DATA_BITS-1:0] want,
		input string field);
		logic [APB_DATA_BITS-1:0] got;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {index, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (got !== want) begin
			mismatch_count++;
			$error("%s: expected %0d, got %0d", field, want, got);
		end
	endtask

	// Receiver: draw a stall before each item, or serve a long hold-off
	// when asked, counted here so the sender keeps pushing meanwhile.
	initial begin
		int w;
		out_ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				out_ready <= 1'b0;
				repeat (RX_HOLD) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				w = rx_calm ? 0 : $urandom_range(0, 7);
				if (w > 0) begin
					out_ready <= 1'b0;
					repeat (w) @(posedge clk);
				end
				out_ready <= 1'b1;
			end
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	// Compare each result item against the oldest prediction.
	always @(posedge clk) begin
		cell_update_t head;
		if (arst_n && out_valid && out_ready) begin
			if (expected_updates.size() == 0) begin
				mismatch_count++;
				$error("new_value: no result expected, got %0d", new_value);
			end else begin
				head = expected_updates.pop_front();
				if (new_value !== head.value) begin
					mismatch_count++;
					$error("new_value: expected %0d, got %0d",
						$signed(head.value), new_value);
				end
				if (grid_done !== head.done) begin
					mismatch_count++;
					$error("grid_done: expected %0b, got %0b", head.done, grid_done);
				end
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb: errors");
				$finish;
			end
		end
	end

	initial begin
		int unsigned pad;
		int unsigned grids;
		int unsigned cells;
		logic [SIZE_BITS-1:0] new_size;
		logic [GAIN_BITS-1:0] new_gain;

		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		cell_value <= '0;
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		paddr      <= '0;
		pwdata     <= '0;
		for (int i = 0; i < MAX_ROW; i++) begin
			upper_row[i]  = '0;
			middle_row[i] = '0;
		end
		west_cell = '0;
		row_pos   = 0;
		col_pos   = 0;
		size_reg  = SIZE_RESET;
		gain_reg  = GAIN_RESET;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Registers come up at their defaults.
		check_reg(REG_INTERIOR_SIZE, APB_DATA_BITS'(SIZE_RESET), "interior_size");
		check_reg(REG_DIFFUSION_GAIN, APB_DATA_BITS'(GAIN_RESET), "diffusion_gain");

		// Directed grids: size zero acts as one interior cell, gain at both ends.
		write_reg(REG_INTERIOR_SIZE, 32'd0);
		write_reg(REG_DIFFUSION_GAIN, 32'hFFFF);
		foreach (directed_rows[i]) begin
			if (directed_rows[i].set_gain) begin
				settle();
				write_reg(REG_DIFFUSION_GAIN, APB_DATA_BITS'(directed_rows[i].gain));
			end
			send_cell(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].value);
		end

		// Mid-size grid, first three padded rows only: the later size write
		// restarts the grid. Stall the receiver long so intake backs up.
		settle();
		tx_calm = 1'b1;
		rx_calm = 1'b0;
		write_reg(REG_INTERIOR_SIZE, APB_DATA_BITS'(PRESSURE_SIZE));
		write_reg(REG_DIFFUSION_GAIN, APB_DATA_BITS'(GAIN_RESET));
		hold_request = 1'b1;
		repeat (3 * padded_len()) send_cell(random_cell(), 1'b0, '0);

		// Random phases: whole grids of random content at small sizes, now and
		// then a grid cut short so the next size write lands mid-grid.
		while (random_count < RANDOM_ITEMS) begin
			settle();
			tx_calm = ($urandom_range(0, 3) == 0);
			rx_calm = ($urandom_range(0, 3) == 0);
			new_size = SIZE_BITS'(($urandom_range(0, 7) == 0) ? $urandom_range(10, 24)
				: $urandom_range(0, 9));
			write_reg(REG_INTERIOR_SIZE, APB_DATA_BITS'(new_size));
			if ($urandom_range(0, 1)) begin
				case ($urandom_range(0, 5))
					0: begin
						new_gain = '0;
					end
					1: begin
						new_gain = '1;
					end
					2: begin
						new_gain = GAIN_RESET;
					end
					default: begin
						new_gain = GAIN_BITS'($urandom);
					end
				endcase
				write_reg(REG_DIFFUSION_GAIN, APB_DATA_BITS'(new_gain));
			end
			pad   = padded_len();
			grids = $urandom_range(1, 3);
			for (int g = 0; g < grids; g++) begin
				cells = pad * pad;
				if (g == grids - 1 && $urandom_range(0, 3) == 0)
					cells = $urandom_range(1, pad * pad - 1);
				if (cells > RANDOM_ITEMS - random_count)
					cells = RANDOM_ITEMS - random_count;
				repeat (cells) begin
					send_cell(random_cell(), 1'b0, '0);
					random_count++;
				end
			end
		end

		// Drain and report.
		settle();
		if (mismatch_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
